FILE: hw/rtl/fsra_pkg.sv
// ----------------------------------------------------------------------------
// fsra_pkg
// Shared constants and controller/datapath interface types for the feed
// sequence reorder arbiter.
// ----------------------------------------------------------------------------
package fsra_pkg;

   localparam int FEED_W         = 8;
   localparam int SEQ_W          = 64;
   localparam int PRICE_W        = 64;
   localparam int DATA_W         = 136;  // feed + seq + price, whole bytes
   localparam int WINDOW_DEFAULT = 32;
   localparam int MAX_RESULTS    = 32;
   localparam int CNT_W          = $clog2(MAX_RESULTS + 1);

   // Result kinds carried on tuser.
   localparam logic KIND_RELEASE = 1'b0;
   localparam logic KIND_REJECT  = 1'b1;

   typedef struct packed {
      logic load;    // capture the accepted transaction
      logic eval;    // classify the held item, start the sequence if needed
      logic store;   // park the held item in the reorder window
      logic reject;  // emit an overflow result
      logic emit;    // emit the update at the expected sequence
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_old;     // below the expected sequence
      logic is_head;    // exactly the expected sequence
      logic in_win;     // ahead of expected, inside the window
      logic out_free;   // result register can take a new result
      logic emit_last;  // the result emitted now ends the run
   } dp_status_type;

endpackage

FILE: hw/rtl/feed_sequence_reorder_arbiter_unit.sv
// ----------------------------------------------------------------------------
// feed_sequence_reorder_arbiter_unit
// Merges sequence-numbered updates from redundant feeds into one in-order
// stream, buffering early arrivals in a reorder window.
//
//   Channel  Direction  Payload
//   req_     in         tdata: feed_id[7:0], seq[71:8], price[135:72]
//   rsp_     out        tdata: out_feed_id[7:0], out_seq[71:8], out_price[135:72]
//                       tuser: kind (1 = beyond window), tlast: last
//
// An update is accepted, then classified, when it is dropped or stored. An
// update at the expected sequence then drains from the window memory one result
// per cycle while the result register is free, up to the result cap, through a
// single result register. Reset is synchronous and clears all slot valid bits
// at once. A stalled result register holds the drain or the reject in place; no
// new transaction is accepted until the current update is finished.
// ----------------------------------------------------------------------------
module feed_sequence_reorder_arbiter_unit #(
   parameter int WINDOW = fsra_pkg::WINDOW_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [fsra_pkg::DATA_W-1:0] req_tdata,   // feed_id, seq, price
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [fsra_pkg::DATA_W-1:0] rsp_tdata,   // out_feed_id, out_seq, out_price
   output logic                        rsp_tuser,   // kind
   output logic                        rsp_tlast
);

   fsra_pkg::ctrl_cmd_type  cmd;
   fsra_pkg::dp_status_type status;

   fsra_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   fsra_datapath #(
      .WINDOW (WINDOW)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

FILE: hw/rtl/fsra_ctrl.sv
// ----------------------------------------------------------------------------
// fsra_ctrl
// Controller state machine: accepts one update, classifies it, then drops,
// stores or rejects it, or drains the in-order run from the reorder window.
// ----------------------------------------------------------------------------
module fsra_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  fsra_pkg::dp_status_type status,
   output fsra_pkg::ctrl_cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_EVAL  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
            if (req_tvalid) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            priority if (status.is_old) begin
               state_in = ST_IDLE;
            end else if (status.is_head) begin
               state_in = ST_DRAIN;
            end else if (status.in_win) begin
               cmd.store = 1'b1;
               state_in  = ST_IDLE;
            end else if (status.out_free) begin
               cmd.reject = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_DRAIN: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hw/rtl/fsra_datapath.sv
// ----------------------------------------------------------------------------
// fsra_datapath
// Sequence tracking, reorder window storage with per-slot valid bits, and the
// registered result stage.
// ----------------------------------------------------------------------------
module fsra_datapath #(
   parameter int WINDOW = fsra_pkg::WINDOW_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [fsra_pkg::DATA_W-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [fsra_pkg::DATA_W-1:0] rsp_tdata,
   output logic                        rsp_tuser,
   output logic                        rsp_tlast,
   input  fsra_pkg::ctrl_cmd_type      cmd,
   output fsra_pkg::dp_status_type     status
);

   localparam int IDX_W = $clog2(WINDOW);
   localparam int ENT_W = fsra_pkg::FEED_W + fsra_pkg::PRICE_W;
   localparam logic [IDX_W:0]   WIN_EXT  = (IDX_W + 1)'(WINDOW);
   localparam logic [IDX_W-1:0] WIN_LAST = IDX_W'(WINDOW - 1);
   localparam logic [fsra_pkg::SEQ_W-1:0] WIN_SEQ = fsra_pkg::SEQ_W'(WINDOW);
   localparam logic [fsra_pkg::CNT_W-1:0] CAP_LAST =
      fsra_pkg::CNT_W'(fsra_pkg::MAX_RESULTS - 1);

   // Held input item.
   logic [fsra_pkg::FEED_W-1:0]  item_feed_ff;
   logic [fsra_pkg::SEQ_W-1:0]   item_seq_ff;
   logic [fsra_pkg::PRICE_W-1:0] item_price_ff;

   // Sequence state. Slots are addressed relative to the expected sequence,
   // so exp_slot_ff tracks the slot of exp_ff without any modulo hardware.
   logic [fsra_pkg::SEQ_W-1:0]   exp_ff;
   logic                         started_ff;
   logic [IDX_W-1:0]             exp_slot_ff;
   logic [WINDOW-1:0]            valid_ff;
   logic [fsra_pkg::CNT_W-1:0]   count_ff;

   logic [ENT_W-1:0]             mem [WINDOW];
   logic [ENT_W-1:0]             rdata_ff;

   // Result register.
   logic                         rsp_valid_ff;
   logic [fsra_pkg::FEED_W-1:0]  out_feed_ff;
   logic [fsra_pkg::SEQ_W-1:0]   out_seq_ff;
   logic [fsra_pkg::PRICE_W-1:0] out_price_ff;
   logic                         out_kind_ff;
   logic                         out_last_ff;

   logic [fsra_pkg::SEQ_W-1:0]   eff_exp;
   logic [fsra_pkg::SEQ_W-1:0]   diff;
   logic [IDX_W:0]               win_sum;
   logic [IDX_W-1:0]             win_slot;
   logic [IDX_W-1:0]             slot_next;
   logic [IDX_W-1:0]             rd_addr;
   logic                         out_free;
   logic                         cur_valid;
   logic                         emit_last;

   always_comb begin
      eff_exp   = started_ff ? exp_ff : item_seq_ff;
      diff      = item_seq_ff - eff_exp;
      win_sum   = {1'b0, exp_slot_ff} + {1'b0, diff[IDX_W-1:0]};
      win_slot  = (win_sum >= WIN_EXT) ? IDX_W'(win_sum - WIN_EXT) : win_sum[IDX_W-1:0];
      slot_next = (exp_slot_ff == WIN_LAST) ? '0 : exp_slot_ff + 1'b1;
      rd_addr   = cmd.emit ? slot_next : exp_slot_ff;
      out_free  = !rsp_valid_ff || rsp_tready;
      cur_valid = valid_ff[exp_slot_ff];
      emit_last = (count_ff == CAP_LAST) || !valid_ff[slot_next];

      status.is_old    = item_seq_ff < eff_exp;
      status.is_head   = diff == '0;
      status.in_win    = diff < WIN_SEQ;
      status.out_free  = out_free;
      status.emit_last = emit_last;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_feed_ff  <= req_tdata[fsra_pkg::FEED_W-1:0];
         item_seq_ff   <= req_tdata[fsra_pkg::FEED_W +: fsra_pkg::SEQ_W];
         item_price_ff <= req_tdata[fsra_pkg::FEED_W + fsra_pkg::SEQ_W +: fsra_pkg::PRICE_W];
      end
   end

   // Window memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.store && !valid_ff[win_slot]) begin
         mem[win_slot] <= {item_feed_ff, item_price_ff};
      end
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff      <= '0;
         started_ff  <= 1'b0;
         exp_slot_ff <= '0;
         valid_ff    <= '0;
         count_ff    <= '0;
      end else begin
         if (cmd.eval) begin
            count_ff <= '0;
            if (!started_ff) begin
               exp_ff      <= item_seq_ff;
               started_ff  <= 1'b1;
               exp_slot_ff <= '0;
            end
         end
         if (cmd.store) begin
            valid_ff[win_slot] <= 1'b1;
         end
         if (cmd.emit) begin
            valid_ff[exp_slot_ff] <= 1'b0;
            exp_ff                <= exp_ff + 1'b1;
            exp_slot_ff           <= slot_next;
            count_ff              <= count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit || cmd.reject) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         // A buffered first arrival takes precedence over the held item.
         out_feed_ff  <= cur_valid ? rdata_ff[ENT_W-1 -: fsra_pkg::FEED_W] : item_feed_ff;
         out_price_ff <= cur_valid ? rdata_ff[fsra_pkg::PRICE_W-1:0] : item_price_ff;
         out_seq_ff   <= exp_ff;
         out_kind_ff  <= fsra_pkg::KIND_RELEASE;
         out_last_ff  <= emit_last;
      end else if (cmd.reject) begin
         out_feed_ff  <= '0;
         out_price_ff <= '0;
         out_seq_ff   <= item_seq_ff;
         out_kind_ff  <= fsra_pkg::KIND_REJECT;
         out_last_ff  <= 1'b1;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {out_price_ff, out_seq_ff, out_feed_ff};
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

FILE: tb/sv/feed_release_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feed_release_checker
// Watches the update stream going into the reorder arbiter, predicts the
// in-order release stream it must produce, and compares each result
// transaction field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module feed_release_checker #(
   parameter int WINDOW = fsra_pkg::WINDOW_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  logic                        req_tready,
   input  logic [fsra_pkg::DATA_W-1:0] req_tdata,   // feed_id, seq, price
   input  logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic [fsra_pkg::DATA_W-1:0] rsp_tdata,   // out_feed_id, out_seq, out_price
   input  logic                        rsp_tuser,   // kind
   input  logic                        rsp_tlast,
   output int                          mismatch_count,
   output int                          outstanding,
   output int                          released_count,
   output int                          rejected_count,
   output int                          longest_drain
);

   localparam int FW = fsra_pkg::FEED_W;
   localparam int SW = fsra_pkg::SEQ_W;
   localparam int PW = fsra_pkg::PRICE_W;

   typedef struct packed {
      logic [FW-1:0]        feed;
      logic [SW-1:0]        seq;
      logic signed [PW-1:0] price;
      logic                 kind;
      logic                 last;
   } feed_result_type;

   feed_result_type release_queue[$];
   feed_result_type seen;
   logic [SW-1:0] next_seq;
   logic          seq_locked;
   logic          held       [WINDOW];
   logic [FW-1:0] held_feed  [WINDOW];
   logic [PW-1:0] held_price [WINDOW];
   int            errors   = 0;
   int            releases = 0;
   int            rejects  = 0;
   int            max_run  = 0;
   int            pending  = 0;
   int            k;

   assign mismatch_count = errors;
   assign outstanding    = pending;
   assign released_count = releases;
   assign rejected_count = rejects;
   assign longest_drain  = max_run;

   function automatic int unsigned window_slot(input logic [SW-1:0] s);
      return int'(s % WINDOW);
   endfunction

   task automatic arbitrate_update(input logic [FW-1:0] feed, input logic [SW-1:0] seq,
                                   input logic [PW-1:0] price);
      logic [SW-1:0]   ahead;
      int unsigned     slot;
      int              produced;
      feed_result_type r;
      if (!seq_locked) begin
         next_seq   = seq;
         seq_locked = 1'b1;
      end
      ahead = seq - next_seq;
      if (seq < next_seq) begin
         return;
      end
      if (ahead == '0) begin
         slot = window_slot(next_seq);
         // A buffered first arrival at the head takes the place of this copy.
         if (held[slot]) begin
            feed       = held_feed[slot];
            price      = held_price[slot];
            held[slot] = 1'b0;
         end
         r.feed  = feed;
         r.seq   = next_seq;
         r.price = price;
         r.kind  = fsra_pkg::KIND_RELEASE;
         r.last  = 1'b0;
         release_queue.push_back(r);
         produced = 1;
         next_seq++;
         while (produced < fsra_pkg::MAX_RESULTS && held[window_slot(next_seq)]) begin
            slot       = window_slot(next_seq);
            r.feed     = held_feed[slot];
            r.seq      = next_seq;
            r.price    = held_price[slot];
            held[slot] = 1'b0;
            release_queue.push_back(r);
            produced++;
            next_seq++;
         end
         r      = release_queue.pop_back();
         r.last = 1'b1;
         release_queue.push_back(r);
         if (produced > max_run) begin
            max_run = produced;
         end
      end else if (ahead < WINDOW) begin
         slot = window_slot(seq);
         if (!held[slot]) begin
            held[slot]       = 1'b1;
            held_feed[slot]  = feed;
            held_price[slot] = price;
         end
      end else begin
         r      = '0;
         r.seq  = seq;
         r.kind = fsra_pkg::KIND_REJECT;
         r.last = 1'b1;
         release_queue.push_back(r);
      end
   endtask

   task automatic check_result(input feed_result_type got);
      feed_result_type want;
      if (release_queue.size() == 0) begin
         errors++;
         if (errors <= 10) begin
            $display("unexpected result: feed %h seq %h price %h kind %b last %b",
                     got.feed, got.seq, got.price, got.kind, got.last);
         end
         return;
      end
      want = release_queue.pop_front();
      if (got.feed !== want.feed || got.seq !== want.seq || got.price !== want.price ||
          got.kind !== want.kind || got.last !== want.last) begin
         errors++;
         if (errors <= 10) begin
            $display("result mismatch: expected feed %h seq %h price %h kind %b last %b",
                     want.feed, want.seq, want.price, want.kind, want.last);
            $display("                 actual   feed %h seq %h price %h kind %b last %b",
                     got.feed, got.seq, got.price, got.kind, got.last);
         end
      end
      if (want.kind == fsra_pkg::KIND_REJECT) begin
         rejects++;
      end else begin
         releases++;
      end
   endtask

   // Inputs change only at the rising edge, so the values seen at the falling
   // edge are the ones the next rising edge acts on. The result side is
   // handled first so that a transaction never matches a prediction made at
   // the same edge.
   always @(negedge clock) begin
      if (reset) begin
         seq_locked = 1'b0;
         next_seq   = '0;
         for (k = 0; k < WINDOW; k++) begin
            held[k] = 1'b0;
         end
         release_queue.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.feed  = rsp_tdata[FW-1:0];
            seen.seq   = rsp_tdata[FW+SW-1:FW];
            seen.price = rsp_tdata[FW+SW+PW-1:FW+SW];
            seen.kind  = rsp_tuser;
            seen.last  = rsp_tlast;
            check_result(seen);
         end
         if (req_tvalid && req_tready) begin
            arbitrate_update(req_tdata[FW-1:0], req_tdata[FW+SW-1:FW],
                             req_tdata[FW+SW+PW-1:FW+SW]);
         end
      end
      pending = release_queue.size();
   end

endmodule

FILE: tb/sv/feed_sequence_reorder_arbiter_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feed_sequence_reorder_arbiter_unit_tb
// Drives sequence-numbered updates into the reorder arbiter: a directed
// opening around sequence wrap, the window edge, drops and duplicates, then
// shuffled runs of consecutive updates with late copies and stray updates,
// under random stalls on both streams and one long result-side hold.
// ----------------------------------------------------------------------------
module feed_sequence_reorder_arbiter_unit_tb;

   localparam int WINDOW       = fsra_pkg::WINDOW_DEFAULT;
   localparam int SW           = fsra_pkg::SEQ_W;
   localparam int RUN_ITEMS    = 200;
   localparam int QUIET_ITEMS  = 40;
   localparam int HOLD_AT      = 100;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 64;
   localparam int CYCLE_LIMIT  = 600000;

   logic                        clock      = 1'b0;
   logic                        reset      = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [fsra_pkg::DATA_W-1:0] req_tdata  = '0;   // feed_id, seq, price
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [fsra_pkg::DATA_W-1:0] rsp_tdata;         // out_feed_id, out_seq, out_price
   logic                        rsp_tuser;         // kind
   logic                        rsp_tlast;

   int       fail_count;
   int       outstanding;
   int       released_count;
   int       rejected_count;
   int       longest_drain;
   int       updates_sent = 0;
   int       run_items    = 0;
   int       cycles       = 0;
   bit       quiet_tail   = 1'b0;
   bit       hold_done    = 1'b0;
   logic [SW-1:0] run_base;

   always #10 clock = ~clock;

   feed_sequence_reorder_arbiter_unit #(
      .WINDOW(WINDOW)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast)
   );

   feed_release_checker #(
      .WINDOW(WINDOW)
   ) i_checker (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .mismatch_count(fail_count),
      .outstanding(outstanding),
      .released_count(released_count),
      .rejected_count(rejected_count),
      .longest_drain(longest_drain)
   );

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still awaited", cycles, outstanding);
         $display("feed_sequence_reorder_arbiter_unit test failed");
         $finish;
      end
   end

   // Offers one update and returns at the edge that takes it. The valid line
   // stays high unless a random pause follows.
   task automatic offer_update(input logic [7:0] feed, input logic [SW-1:0] seq,
                               input logic [63:0] price);
      logic taken;
      req_tvalid <= 1'b1;
      req_tdata  <= {price, seq, feed};
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
      updates_sent++;
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // Sends the consecutive updates from run_base in shuffled order, with late
   // copies and stray updates mixed in. A full-window run holds its head back
   // to the end so the whole window drains in one go.
   task automatic send_shuffled_run();
      logic [SW-1:0] order[$];
      logic [SW-1:0] swap;
      int            len;
      int            j;
      int            k;
      bit            full;
      full = ($urandom_range(0, 7) == 0);
      len  = full ? WINDOW : $urandom_range(1, 8);
      for (k = full ? 1 : 0; k < len; k++) begin
         order.push_back(run_base + k);
      end
      for (k = order.size() - 1; k > 0; k--) begin
         j        = $urandom_range(0, k);
         swap     = order[k];
         order[k] = order[j];
         order[j] = swap;
      end
      if (full) begin
         order.push_back(run_base);
      end
      for (k = 0; k < order.size(); k++) begin
         offer_update(8'($urandom_range(0, 255)), order[k], {$urandom, $urandom});
         run_items++;
         quiet_tail = (run_items >= RUN_ITEMS - QUIET_ITEMS);
         if ($urandom_range(0, 5) == 0) begin
            offer_update(8'($urandom_range(0, 255)), order[$urandom_range(0, k)],
                         {$urandom, $urandom});
         end
         if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 2))
               0: begin
                  offer_update(8'($urandom_range(0, 255)),
                               run_base - $urandom_range(1, 40),
                               {$urandom, $urandom});
               end
               1: begin
                  offer_update(8'($urandom_range(0, 255)),
                               run_base + WINDOW + $urandom_range(0, 1000),
                               {$urandom, $urandom});
               end
               default: begin
                  offer_update(8'($urandom_range(0, 255)), {$urandom, $urandom},
                               {$urandom, $urandom});
               end
            endcase
         end
      end
      run_base += len;
   endtask

   // Result-side ready: random stalls, long ready stretches, and one long
   // hold once the run is well under way so the block backs up its input.
   initial begin
      wait (!reset);
      @(posedge clock);
      forever begin
         if (!hold_done && run_items >= HOLD_AT) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The first update sets the expected sequence just below the wrap point.
      offer_update(8'h00, 64'hFFFF_FFFF_FFFF_FFFE, 64'h7FFF_FFFF_FFFF_FFFF);
      offer_update(8'hFF, 64'hFFFF_FFFF_FFFF_FFFD, 64'h0000_0000_0000_0001);
      // Numerically below the expected sequence, so it is dropped.
      offer_update(8'h5A, 64'h0000_0000_0000_0003, 64'h1234_5678_9ABC_DEF0);
      // Released; the expected sequence wraps to zero.
      offer_update(8'hA5, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
      offer_update(8'h11, 64'd2, 64'hFFFF_FFFF_FFFF_FFFF);
      offer_update(8'hFF, 64'd3, 64'h8000_0000_0000_0000);
      offer_update(8'h22, 64'd2, 64'h0000_0000_0000_0005);
      offer_update(8'h33, 64'd31, 64'h0F0F_0F0F_0F0F_0F0F);
      offer_update(8'h44, 64'd32, 64'hFFFF_0000_FFFF_0000);
      offer_update(8'h55, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000);
      offer_update(8'h66, 64'd0, 64'h0000_0000_0000_0000);
      offer_update(8'h77, 64'd1, 64'hAAAA_AAAA_AAAA_AAAA);
      offer_update(8'h88, 64'd3, 64'h5555_5555_5555_5555);
      offer_update(8'h99, 64'd35, 64'h7FFF_FFFF_FFFF_FFFE);
      offer_update(8'hCC, 64'd36, 64'hC3C3_C3C3_C3C3_C3C3);

      run_base = 64'd4;
      while (run_items < RUN_ITEMS) begin
         send_shuffled_run();
      end
      req_tvalid <= 1'b0;

      while (outstanding != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d updates (%0d in shuffled runs), checked %0d releases and %0d rejects.",
               updates_sent, run_items, released_count, rejected_count);
      $display("Longest drain was %0d results; one %0d-cycle result hold backed up the input.",
               longest_drain, HOLD_CYCLES);
      if (fail_count == 0 && outstanding == 0) begin
         $display("feed_sequence_reorder_arbiter_unit test passed");
      end else begin
         $display("feed_sequence_reorder_arbiter_unit test failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/fsra_pkg.sv
hw/rtl/fsra_ctrl.sv
hw/rtl/fsra_datapath.sv
hw/rtl/feed_sequence_reorder_arbiter_unit.sv
tb/sv/feed_release_checker.sv
tb/sv/feed_sequence_reorder_arbiter_unit_tb.sv
